// ===== design/fvcw_pkg.sv =====
// ----------------------------------------------------------------------------
// fvcw_pkg
// shared types, constants and the color wheel for the flow color coder
// ----------------------------------------------------------------------------
package fvcw_pkg;

    localparam int FLOW_WIDTH     = 16;
    localparam int MOTION_W       = 16;
    localparam logic [MOTION_W-1:0] MOTION_RESET = 16'd2560;

    localparam int WHEEL_SIZE     = 55;
    localparam int SPAN_A         = 15;
    localparam int SPAN_B         = 6;
    localparam int SPAN_C         = 4;
    localparam int SPAN_D         = 11;
    localparam int SPAN_E         = 13;
    localparam int SPAN_F         = 6;
    localparam int KEY_W          = 6;

    localparam int CORDIC_STEPS   = 30;
    localparam int PRESCALE_SHIFT = 24;
    localparam int PHASE_W        = 32;
    localparam int FRAC_W         = 16;
    localparam int ROOT_W         = 32;
    localparam int QUOT_W         = 17;
    localparam int CHAN_W         = 8;
    localparam int BLEND_W        = 24;

    // latency in cycles from accept to the registered unit outputs
    localparam int ANGLE_LAT      = CORDIC_STEPS + 2;
    localparam int RADIUS_LAT     = 3 + ROOT_W + 1 + QUOT_W;
    localparam int ALIGN_LAT      = RADIUS_LAT - ANGLE_LAT;

    typedef struct packed {
        logic signed [FLOW_WIDTH-1:0] flow_x;
        logic signed [FLOW_WIDTH-1:0] flow_y;
        logic                         flow_valid;
    } request_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } color_t;

    // atan(2^-i) as a fraction of a full turn, 32 fraction bits
    localparam logic [PHASE_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    // floor(255 * i / span) ramps
    localparam logic [7:0] RAMP_6  [SPAN_B] = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212};
    localparam logic [7:0] RAMP_4  [SPAN_C] = '{8'd0, 8'd63, 8'd127, 8'd191};
    localparam logic [7:0] RAMP_11 [SPAN_D] = '{8'd0, 8'd23, 8'd46, 8'd69, 8'd92, 8'd115,
                                                8'd139, 8'd162, 8'd185, 8'd208, 8'd231};
    localparam logic [7:0] RAMP_13 [SPAN_E] = '{8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98,
                                                8'd117, 8'd137, 8'd156, 8'd176, 8'd196,
                                                8'd215, 8'd235};

    function automatic color_t wheel_color(input logic [KEY_W-1:0] k);
        color_t           c;
        logic [KEY_W-1:0] i;
        c = '0;
        i = '0;
        if (k < KEY_W'(SPAN_A)) begin
            c.r = 8'd255;
            c.g = {k[3:0], 4'b0000} + {4'b0000, k[3:0]};
        end else if (k < KEY_W'(SPAN_A + SPAN_B)) begin
            i   = k - KEY_W'(SPAN_A);
            c.r = 8'd255 - RAMP_6[i[2:0]];
            c.g = 8'd255;
        end else if (k < KEY_W'(SPAN_A + SPAN_B + SPAN_C)) begin
            i   = k - KEY_W'(SPAN_A + SPAN_B);
            c.g = 8'd255;
            c.b = RAMP_4[i[1:0]];
        end else if (k < KEY_W'(SPAN_A + SPAN_B + SPAN_C + SPAN_D)) begin
            i   = k - KEY_W'(SPAN_A + SPAN_B + SPAN_C);
            c.g = 8'd255 - RAMP_11[i[3:0]];
            c.b = 8'd255;
        end else if (k < KEY_W'(SPAN_A + SPAN_B + SPAN_C + SPAN_D + SPAN_E)) begin
            i   = k - KEY_W'(SPAN_A + SPAN_B + SPAN_C + SPAN_D);
            c.r = RAMP_13[i[3:0]];
            c.b = 8'd255;
        end else if (k < KEY_W'(WHEEL_SIZE)) begin
            i   = k - KEY_W'(SPAN_A + SPAN_B + SPAN_C + SPAN_D + SPAN_E);
            c.r = 8'd255;
            c.b = 8'd255 - RAMP_6[i[2:0]];
        end
        return c;
    endfunction

endpackage

// ===== design/fvcw_angle.sv =====
// ----------------------------------------------------------------------------
// fvcw_angle
// pipelined cordic vectoring: flow direction to wheel index and blend weight
// ----------------------------------------------------------------------------
module fvcw_angle (
    input  logic                                    clk,
    input  logic signed [fvcw_pkg::FLOW_WIDTH-1:0]  flow_x,
    input  logic signed [fvcw_pkg::FLOW_WIDTH-1:0]  flow_y,
    output logic [fvcw_pkg::KEY_W-1:0]              k0,
    output logic [fvcw_pkg::FRAC_W-1:0]             frac
);
    import fvcw_pkg::*;

    localparam int CW = FLOW_WIDTH + PRESCALE_SHIFT + 3;
    localparam int QW = PHASE_W + KEY_W;

    logic signed [CW-1:0]      x_reg    [CORDIC_STEPS+1];
    logic signed [CW-1:0]      y_reg    [CORDIC_STEPS+1];
    logic [PHASE_W-1:0]        z_reg    [CORDIC_STEPS+1];
    logic                      base_reg [CORDIC_STEPS+1];
    logic                      axis_reg [CORDIC_STEPS+1];
    logic [KEY_W-1:0]          k0_reg;
    logic [FRAC_W-1:0]         frac_reg;

    logic signed [FLOW_WIDTH:0] xe, ye, xm, ym;
    logic                       neg;
    logic [PHASE_W-1:0]         phase;
    logic [QW-1:0]              q;

    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                   input int s);
        logic signed [CW-1:0] r;
        if (v < 0)
            r = -((-v) >>> s);
        else
            r = v >>> s;
        return r;
    endfunction

    // mirror into the right half plane
    always_comb
    begin
        xe  = (FLOW_WIDTH+1)'(flow_x);
        ye  = (FLOW_WIDTH+1)'(flow_y);
        neg = xe < 0;
        xm  = neg ? -xe : xe;
        ym  = neg ? -ye : ye;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CW'(xm) <<< PRESCALE_SHIFT;
        y_reg[0]    <= CW'(ym) <<< PRESCALE_SHIFT;
        z_reg[0]    <= '0;
        base_reg[0] <= neg;
        axis_reg[0] <= (flow_y == '0);
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CW-1:0] dx, dy;
        assign dx = shr_tz(y_reg[i], i);
        assign dy = shr_tz(x_reg[i], i);
        always_ff @(posedge clk)
        begin
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + TURN_ATAN[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - TURN_ATAN[i];
            end
            base_reg[i+1] <= base_reg[i];
            axis_reg[i+1] <= axis_reg[i];
        end
    end

    // on the x axis the phase is just the half-turn base
    always_comb
    begin
        phase = {base_reg[CORDIC_STEPS], {(PHASE_W-1){1'b0}}};
        if (!axis_reg[CORDIC_STEPS])
            phase = phase + z_reg[CORDIC_STEPS];
        q = QW'(phase) * QW'(WHEEL_SIZE - 1);
    end

    always_ff @(posedge clk)
    begin
        k0_reg   <= q[QW-1:PHASE_W];
        frac_reg <= q[PHASE_W-1:PHASE_W-FRAC_W];
    end

    assign k0   = k0_reg;
    assign frac = frac_reg;

endmodule

// ===== design/fvcw_radius.sv =====
// ----------------------------------------------------------------------------
// fvcw_radius
// squared radius, saturation test, digit-serial square root and divide stages
// ----------------------------------------------------------------------------
module fvcw_radius (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [fvcw_pkg::FLOW_WIDTH-1:0]  flow_x,
    input  logic signed [fvcw_pkg::FLOW_WIDTH-1:0]  flow_y,
    input  logic [fvcw_pkg::MOTION_W-1:0]           motion,
    output logic                                    out_valid,
    output logic                                    out_sat,
    output logic [fvcw_pkg::QUOT_W-1:0]             out_quot
);
    import fvcw_pkg::*;

    localparam int SQ_W  = 2 * FLOW_WIDTH;
    localparam int R2_W  = (SQ_W > 2 * MOTION_W) ? SQ_W : 2 * MOTION_W;
    localparam int V_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [MOTION_W-1:0]   m_eff;
    logic [2*MOTION_W-1:0] mm_reg;

    logic                  v1_reg, v2_reg;
    logic [FLOW_WIDTH-1:0] ax_reg, ay_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;

    logic                  sv_reg   [ROOT_W+1];
    logic                  ssat_reg [ROOT_W+1];
    logic [V_W-1:0]        v_reg    [ROOT_W+1];
    logic [REM_W-1:0]      rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]     root_reg [ROOT_W+1];

    logic                  dv_reg    [QUOT_W+1];
    logic                  dsat_reg  [QUOT_W+1];
    logic [QUOT_W-1:0]     drem_reg  [QUOT_W+1];
    logic [QUOT_W-1:0]     dbits_reg [QUOT_W+1];
    logic [QUOT_W-1:0]     dquot_reg [QUOT_W+1];

    logic signed [FLOW_WIDTH:0] xe, ye;
    logic [R2_W-1:0]            r2;
    logic                       sat;

    assign m_eff = (motion == '0) ? MOTION_W'(1) : motion;

    always_comb
    begin
        xe  = (FLOW_WIDTH+1)'(flow_x);
        ye  = (FLOW_WIDTH+1)'(flow_y);
        r2  = R2_W'(sqx_reg) + R2_W'(sqy_reg);
        sat = r2 <= R2_W'(mm_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i <= ROOT_W; i++)
                sv_reg[i] <= 1'b0;
            for (int j = 0; j <= QUOT_W; j++)
                dv_reg[j] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            sv_reg[0] <= v2_reg;
            for (int i = 1; i <= ROOT_W; i++)
                sv_reg[i] <= sv_reg[i-1];
            dv_reg[0] <= sv_reg[ROOT_W];
            for (int j = 1; j <= QUOT_W; j++)
                dv_reg[j] <= dv_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mm_reg      <= (2*MOTION_W)'(m_eff) * (2*MOTION_W)'(m_eff);
        ax_reg      <= FLOW_WIDTH'((xe < 0) ? -xe : xe);
        ay_reg      <= FLOW_WIDTH'((ye < 0) ? -ye : ye);
        sqx_reg     <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg     <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        // the root is used only for a saturating radius, and then r2 fits 32 bits
        v_reg[0]    <= {r2[ROOT_W-1:0], {ROOT_W{1'b0}}};
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        ssat_reg[0] <= sat;
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W+1:0] rem_t, trial;
        assign rem_t = {rem_reg[k], v_reg[k][V_W-1:V_W-2]};
        assign trial = {2'b00, root_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (rem_t >= trial)
            begin
                rem_reg[k+1]  <= REM_W'(rem_t - trial);
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1]  <= REM_W'(rem_t);
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
            end
            v_reg[k+1]    <= {v_reg[k][V_W-3:0], 2'b00};
            ssat_reg[k+1] <= ssat_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg[0]  <= QUOT_W'(root_reg[ROOT_W][ROOT_W-1:QUOT_W]);
        dbits_reg[0] <= root_reg[ROOT_W][QUOT_W-1:0];
        dquot_reg[0] <= '0;
        dsat_reg[0]  <= ssat_reg[ROOT_W];
    end

    // restoring divide by the motion limit, one quotient bit per stage
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        logic [QUOT_W:0] t;
        assign t = {drem_reg[j], dbits_reg[j][QUOT_W-1]};
        always_ff @(posedge clk)
        begin
            if (t >= (QUOT_W+1)'(m_eff))
            begin
                drem_reg[j+1]  <= QUOT_W'(t - (QUOT_W+1)'(m_eff));
                dquot_reg[j+1] <= {dquot_reg[j][QUOT_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg[j+1]  <= QUOT_W'(t);
                dquot_reg[j+1] <= {dquot_reg[j][QUOT_W-2:0], 1'b0};
            end
            dbits_reg[j+1] <= {dbits_reg[j][QUOT_W-2:0], 1'b0};
            dsat_reg[j+1]  <= dsat_reg[j];
        end
    end

    assign out_valid = dv_reg[QUOT_W];
    assign out_sat   = dsat_reg[QUOT_W];
    assign out_quot  = dquot_reg[QUOT_W];

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg[ROOT_W] && ssat_reg[ROOT_W]) |->
        (root_reg[ROOT_W] <= {m_eff, {FRAC_W{1'b0}}}))
        else $error("root exceeds limit of saturating radius");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[QUOT_W] && dsat_reg[QUOT_W]) |->
        (dquot_reg[QUOT_W] <= QUOT_W'(1 << FRAC_W)))
        else $error("normalized radius above one on saturating path");

endmodule

// ===== design/fvcw_blend.sv =====
// ----------------------------------------------------------------------------
// fvcw_blend
// wheel lookup, linear blend, saturation and output register
// ----------------------------------------------------------------------------
module fvcw_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          flow_ok,
    input  logic [fvcw_pkg::KEY_W-1:0]    k0,
    input  logic [fvcw_pkg::FRAC_W-1:0]   frac,
    input  logic                          sat,
    input  logic [fvcw_pkg::QUOT_W-1:0]   quot,
    output logic                          done,
    output fvcw_pkg::pixel_t              pixel
);
    import fvcw_pkg::*;

    localparam int PROD_W = QUOT_W + BLEND_W;
    localparam int CEIL_W = PROD_W + 1;
    localparam int TRI_W  = BLEND_W + 2;
    localparam logic [BLEND_W-1:0] FULL = BLEND_W'(255 << FRAC_W);

    logic                v1_reg, v2_reg, done_reg;
    logic                ok1_reg, ok2_reg, sat1_reg, sat2_reg;
    logic [QUOT_W-1:0]   quot1_reg;
    logic [BLEND_W-1:0]  b1_reg   [3];
    logic [BLEND_W-1:0]  b2_reg   [3];
    logic [PROD_W-1:0]   prod_reg [3];
    pixel_t              pixel_reg;

    logic [KEY_W-1:0]    k1;
    color_t              c0, c1;
    logic [CHAN_W-1:0]   w0 [3];
    logic [CHAN_W-1:0]   w1 [3];
    logic [CHAN_W-1:0]   ch_next [3];
    pixel_t              pixel_next;

    always_comb
    begin
        k1    = (k0 == KEY_W'(WHEEL_SIZE - 1)) ? '0 : k0 + KEY_W'(1);
        c0    = wheel_color(k0);
        c1    = wheel_color(k1);
        w0[0] = c0.r;
        w0[1] = c0.g;
        w0[2] = c0.b;
        w1[0] = c1.r;
        w1[1] = c1.g;
        w1[2] = c1.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [CEIL_W-1:0] up;
            logic [TRI_W-1:0]  tri3;
            up   = CEIL_W'(prod_reg[c]) + CEIL_W'(32'hFFFF_FFFF);
            tri3 = TRI_W'(b2_reg[c]) * TRI_W'(3);
            if (!ok2_reg)
                ch_next[c] = '0;
            else if (sat2_reg)
                ch_next[c] = 8'd255 - up[CHAN_W+31:32];
            else
                ch_next[c] = tri3[TRI_W-1:TRI_W-CHAN_W];
        end
        pixel_next.red   = ch_next[0];
        pixel_next.green = ch_next[1];
        pixel_next.blue  = ch_next[2];
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            b1_reg[c]   <= BLEND_W'((BLEND_W+1)'((FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(frac))
                              * (BLEND_W+1)'(w0[c])
                         + (BLEND_W+1)'(frac) * (BLEND_W+1)'(w1[c]));
            b2_reg[c]   <= b1_reg[c];
            prod_reg[c] <= PROD_W'(quot1_reg) * PROD_W'(FULL - b1_reg[c]);
        end
        ok1_reg   <= flow_ok;
        sat1_reg  <= sat;
        quot1_reg <= quot;
        ok2_reg   <= ok1_reg;
        sat2_reg  <= sat1_reg;
        pixel_reg <= pixel_next;
    end

    assign done  = done_reg;
    assign pixel = pixel_reg;

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (k0 <= KEY_W'(WHEEL_SIZE - 2)))
        else $error("wheel index out of range");

endmodule

// ===== design/flow_vector_color_wheel_unit.sv =====
// ----------------------------------------------------------------------------
// flow_vector_color_wheel_unit
// flow vector to blue-green-red pixel, optical flow color coding
// ----------------------------------------------------------------------------
// One request is taken in every clock cycle (busy is always low) and its pixel
// appears on result with done high after the radius and blend registers,
// in request order; the receiver must take it in that cycle. The radius path
// holds the square root (32 stages, one root bit each) and the divide by the
// motion limit (17 stages); the 30-stage cordic angle path is delayed to meet
// it. The user must write max_motion (motion_reg) through cfg_we / cfg_data
// only while no request is in flight; the block itself does not enforce it.
module flow_vector_color_wheel_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  fvcw_pkg::request_t                  request,
    input  logic                                cfg_we,
    input  logic [fvcw_pkg::MOTION_W-1:0]       cfg_data,
    output logic                                done,
    output fvcw_pkg::pixel_t                    result
);
    import fvcw_pkg::*;

    logic [MOTION_W-1:0]  motion_reg;
    logic                 accept;

    logic [KEY_W-1:0]     ang_k0;
    logic [FRAC_W-1:0]    ang_frac;
    logic                 rad_valid, rad_sat;
    logic [QUOT_W-1:0]    rad_quot;

    logic [KEY_W-1:0]     k0_dly_reg   [ALIGN_LAT];
    logic [FRAC_W-1:0]    frac_dly_reg [ALIGN_LAT];
    logic                 ok_dly_reg   [RADIUS_LAT];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            motion_reg <= MOTION_RESET;
        else if (cfg_we)
            motion_reg <= cfg_data;
    end

    fvcw_angle u_angle (
        .clk    (clk),
        .flow_x (request.flow_x),
        .flow_y (request.flow_y),
        .k0     (ang_k0),
        .frac   (ang_frac)
    );

    fvcw_radius u_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .flow_x    (request.flow_x),
        .flow_y    (request.flow_y),
        .motion    (motion_reg),
        .out_valid (rad_valid),
        .out_sat   (rad_sat),
        .out_quot  (rad_quot)
    );

    // line up the angle and the valid flag with the radius path
    always_ff @(posedge clk)
    begin
        k0_dly_reg[0]   <= ang_k0;
        frac_dly_reg[0] <= ang_frac;
        for (int i = 1; i < ALIGN_LAT; i++)
        begin
            k0_dly_reg[i]   <= k0_dly_reg[i-1];
            frac_dly_reg[i] <= frac_dly_reg[i-1];
        end
        ok_dly_reg[0] <= request.flow_valid;
        for (int j = 1; j < RADIUS_LAT; j++)
            ok_dly_reg[j] <= ok_dly_reg[j-1];
    end

    fvcw_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rad_valid),
        .flow_ok  (ok_dly_reg[RADIUS_LAT-1]),
        .k0       (k0_dly_reg[ALIGN_LAT-1]),
        .frac     (frac_dly_reg[ALIGN_LAT-1]),
        .sat      (rad_sat),
        .quot     (rad_quot),
        .done     (done),
        .pixel    (result)
    );

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(rad_valid, 3))
        else $error("result without a request from the radius path");

    a_black_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (rad_valid && !ok_dly_reg[RADIUS_LAT-1]) |=> ##2 (done && (result == '0)))
        else $error("invalid flow did not give a black pixel");

endmodule

// ===== sim/flow_vector_color_wheel_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_vector_color_wheel_unit_test
// drives flow vectors into the color coder, predicts each pixel with a local
// cordic / square root / blend model and compares every result in order
// ----------------------------------------------------------------------------
module flow_vector_color_wheel_unit_test;
    import fvcw_pkg::*;

    localparam int DRAIN_CYCLES = 80;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     cfg_we;
    logic [MOTION_W-1:0] cfg_data;
    logic     done;
    pixel_t   result;

    pixel_t pending_pixels[$];
    logic [MOTION_W-1:0] motion_limit;
    int  mismatch_count;
    bit  quiet_phase;

    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    flow_vector_color_wheel_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    always #5 clk = ~clk;

    function automatic longint trunc_shift(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] flow_phase(longint x, longint y);
        logic [31:0] base;
        longint      z;
        longint      dx;
        longint      dy;
        base = 32'h0;
        z = 0;
        if (y == 0)
            return (x < 0) ? 32'h8000_0000 : 32'h0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = 32'h8000_0000;
        end
        x = x <<< PRESCALE_SHIFT;
        y = y <<< PRESCALE_SHIFT;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = trunc_shift(y, i);
            dy = trunc_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end
        end
        return base + z[31:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = 64'h1 << 62;
        while (one > v)
            one >>= 2;
        while (one != 0)
        begin
            if (v >= res + one)
            begin
                v -= res + one;
                res = (res >> 1) + one;
            end
            else
                res >>= 1;
            one >>= 2;
        end
        return res;
    endfunction

    // ch: 0 red, 1 green, 2 blue
    function automatic int wheel_level(int k, int ch);
        int r, g, b, i;
        r = 0; g = 0; b = 0;
        if (k < 15) begin i = k; r = 255; g = 255 * i / 15; end
        else if (k < 21) begin i = k - 15; r = 255 - 255 * i / 6; g = 255; end
        else if (k < 25) begin i = k - 21; g = 255; b = 255 * i / 4; end
        else if (k < 36) begin i = k - 25; g = 255 - 255 * i / 11; b = 255; end
        else if (k < 49) begin i = k - 36; r = 255 * i / 13; b = 255; end
        else if (k < 55) begin i = k - 49; r = 255; b = 255 - 255 * i / 6; end
        return ch == 0 ? r : (ch == 1 ? g : b);
    endfunction

    function automatic pixel_t code_pixel(request_t req, logic [MOTION_W-1:0] lim);
        pixel_t          px;
        longint          x, y;
        longint unsigned m, q, f, r2, rq, bl, d, v;
        int              k0, k1;
        bit              sat;
        logic [7:0]      chan [3];
        px = '0;
        rq = 0;
        if (!req.flow_valid)
            return px;
        x = longint'(req.flow_x);
        y = longint'(req.flow_y);
        m = (lim == 0) ? 1 : lim;
        q = {32'h0, flow_phase(x, y)} * 64'd54;
        k0 = int'(q >> 32);
        k1 = (k0 + 1) % WHEEL_SIZE;
        f = (q >> 16) & 64'hFFFF;
        r2 = longint'(x * x + y * y);
        sat = r2 <= m * m;
        if (sat)
            rq = root64(r2 << 32) / m;
        for (int ch = 0; ch < 3; ch++)
        begin
            bl = (65536 - f) * wheel_level(k0, ch) + f * wheel_level(k1, ch);
            if (sat)
            begin
                d = 255 * 65536 - bl;
                v = 255 - ((rq * d + 64'hFFFF_FFFF) >> 32);
            end
            else
                v = (3 * bl) >> 18;
            chan[ch] = v[7:0];
        end
        px.red = chan[0];
        px.green = chan[1];
        px.blue = chan[2];
        return px;
    endfunction

    task automatic send_flow(logic signed [15:0] fx, logic signed [15:0] fy, logic fv);
        request_t req;
        req.flow_x = fx;
        req.flow_y = fy;
        req.flow_valid = fv;
        while (!quiet_phase && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pixels.push_back(code_pixel(req, motion_limit));
    endtask

    task automatic set_motion_limit(logic [MOTION_W-1:0] lim);
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        motion_limit = lim;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pixel %h", result);
            end
            else
            begin
                if (result.blue !== pending_pixels[0].blue ||
                    result.green !== pending_pixels[0].green ||
                    result.red !== pending_pixels[0].red)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pixel mismatch: expected %h actual %h",
                                 pending_pixels[0], result);
                end
                void'(pending_pixels.pop_front());
            end
        end
    end

    task automatic test_directed_extremes();
        send_flow(16'sd0, 16'sd0, 1'b1);
        send_flow(16'sd100, 16'sd100, 1'b0);
        send_flow(16'sh7FFF, 16'sd0, 1'b1);
        send_flow(-16'sh8000, 16'sd0, 1'b1);
        send_flow(16'sd0, 16'sh7FFF, 1'b1);
        send_flow(16'sd0, -16'sh8000, 1'b1);
        send_flow(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_flow(-16'sh8000, -16'sh8000, 1'b1);
        send_flow(16'sd1000, -16'sd1, 1'b1);
        send_flow(-16'sd1, 16'sd1000, 1'b1);
        send_flow(16'sd1810, 16'sd1810, 1'b1);
        send_flow(16'sd2560, 16'sd0, 1'b1);
        send_flow(16'sd2561, 16'sd0, 1'b1);
        send_flow(-16'sd1, -16'sd1, 1'b1);
        send_flow(16'shFFFF, 16'sh8000, 1'b0);
    endtask

    task automatic test_random_flow(int count, int span);
        logic signed [15:0] fx, fy;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
            begin
                fx = 16'($urandom);
                fy = 16'($urandom);
            end
            else
            begin
                fx = 16'($urandom_range(2 * span) - span);
                fy = 16'($urandom_range(2 * span) - span);
            end
            send_flow(fx, fy, $urandom_range(9) != 0);
        end
    endtask

    task automatic test_motion_limits();
        set_motion_limit(16'd1);
        send_flow(16'sd0, 16'sd1, 1'b1);
        send_flow(16'sd1, 16'sd0, 1'b1);
        test_random_flow(150, 4);
        set_motion_limit(16'hFFFF);
        send_flow(16'sh7FFF, 16'sh7FFF, 1'b1);
        test_random_flow(300, 32768);
        set_motion_limit(16'd0);
        test_random_flow(100, 3);
        set_motion_limit(16'($urandom_range(65535, 1)));
        test_random_flow(300, 20000);
        set_motion_limit(16'd2560);
        quiet_phase = 1'b1;
        test_random_flow(300, 4000);
        quiet_phase = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        quiet_phase = 1'b0;
        motion_limit = MOTION_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_random_flow(930, 3000);
        test_motion_limits();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fvcw_pkg.sv
design/fvcw_angle.sv
design/fvcw_radius.sv
design/fvcw_blend.sv
design/flow_vector_color_wheel_unit.sv
sim/flow_vector_color_wheel_unit_test.sv
